### rtl/emst_pkg.sv
package emst_pkg;

  localparam int ANGLE_IN_W     = 14;
  localparam int ANGLE_BITS_DEF = 14;
  localparam int TURN_W         = 32;
  localparam int POS_W          = 46;
  localparam int SPEED_W        = 15;
  localparam int THR_W          = 14;
  localparam int GLITCH_W       = 15;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 15;
  localparam int S_TDATA_W      = 16;
  localparam int M_TDATA_W      = 96;

  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(1000);
  localparam logic [GLITCH_W-1:0] GLITCH_RESET = GLITCH_W'(1500);

  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(16383);
  localparam logic [SPEED_W-1:0] SPEED_MIN = SPEED_W'(16384);

  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GLITCH    = CFG_ADDR_W'(1);

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [POS_W-1:0]   position;
    logic [TURN_W-1:0]  turn;
  } result_t;

endpackage

### rtl/emst_cfg.sv
module emst_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [emst_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [emst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [emst_pkg::THR_W-1:0]        threshold,
  output logic [emst_pkg::GLITCH_W-1:0]     glitch_limit
);
  import emst_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THR_RESET;
      glitch_limit <= GLITCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_THRESHOLD: threshold    <= cfg_wdata[THR_W-1:0];
        REG_GLITCH:    glitch_limit <= cfg_wdata[GLITCH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/emst_track.sv
module emst_track #(
  parameter int ANGLE_BITS = emst_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [emst_pkg::ANGLE_IN_W-1:0]   angle_in,
  input  logic [emst_pkg::THR_W-1:0]        threshold,
  input  logic [emst_pkg::GLITCH_W-1:0]     glitch_limit,
  output emst_pkg::result_t                 res
);
  import emst_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam logic signed [AB:0] HALF_S     = (AB+1)'(1) << (AB-1);
  localparam logic signed [AB:0] NEG_HALF_S = -HALF_S;

  logic [AB-1:0]      last_angle;
  logic [AB-1:0]      fast_last_angle;
  logic [TURN_W-1:0]  revolution;
  logic [POS_W-1:0]   slow_last_position;
  logic [SPEED_W-1:0] last_speed;

  logic [AB+ANGLE_IN_W-1:0]   angle_ext;
  logic [AB-1:0]              angle;
  logic [AB:0]                drop;
  logic [TURN_W-1:0]          revolution_next;
  logic [TURN_W+2*AB-1:0]     pos_wide;
  logic [POS_W-1:0]           pos;
  logic                       slow;
  logic [POS_W-1:0]           diff;
  logic [POS_W-1:0]           mag;
  logic                       accept;
  logic [SPEED_W-1:0]         slow_speed;
  logic [AB-1:0]              fast_diff;
  logic [AB+SPEED_W-1:0]      fast_ext;
  logic [SPEED_W-1:0]         fast_speed;
  logic [SPEED_W-1:0]         speed_next;

  always_comb begin
    angle_ext = {{AB{1'b0}}, angle_in};
    angle     = angle_ext[AB-1:0];
    drop      = {1'b0, last_angle} - {1'b0, angle};

    revolution_next = revolution;
    if ($signed(drop) > HALF_S) begin
      revolution_next = revolution + TURN_W'(1);
    end else if ($signed(drop) < NEG_HALF_S) begin
      revolution_next = revolution - TURN_W'(1);
    end

    pos_wide = {{AB{revolution_next[TURN_W-1]}}, revolution_next, angle};
    pos      = pos_wide[POS_W-1:0];

    slow = $signed({last_speed[SPEED_W-1], last_speed}) <= $signed({2'b00, threshold});

    diff   = pos - slow_last_position;
    mag    = diff[POS_W-1] ? (POS_W'(0) - diff) : diff;
    accept = mag < {{(POS_W-GLITCH_W){1'b0}}, glitch_limit};

    if (!diff[POS_W-1]) begin
      slow_speed = (mag > {{(POS_W-SPEED_W){1'b0}}, SPEED_MAX}) ? SPEED_MAX : mag[SPEED_W-1:0];
    end else begin
      slow_speed = (mag > {{(POS_W-SPEED_W){1'b0}}, SPEED_MIN}) ? SPEED_MIN
                                                                : (SPEED_W'(0) - mag[SPEED_W-1:0]);
    end

    fast_diff  = angle - fast_last_angle;
    fast_ext   = {{SPEED_W{1'b0}}, fast_diff};
    fast_speed = (fast_ext > (AB+SPEED_W)'(SPEED_MAX)) ? SPEED_MAX : fast_ext[SPEED_W-1:0];

    if (slow) begin
      speed_next = accept ? slow_speed : last_speed;
    end else begin
      speed_next = fast_speed;
    end

    res.turn     = revolution_next;
    res.position = pos;
    res.speed    = speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle         <= '0;
      fast_last_angle    <= '0;
      revolution         <= '0;
      slow_last_position <= '0;
      last_speed         <= '0;
    end else if (step) begin
      last_angle <= angle;
      revolution <= revolution_next;
      last_speed <= speed_next;
      if (slow) begin
        slow_last_position <= pos;
      end else begin
        fast_last_angle <= angle;
      end
    end
  end

endmodule

### rtl/encoder_multiturn_speed_tracker.sv
// Channel  | Signals                          | Contents
// s_axis   | s_tvalid s_tready s_tdata[15:0]  | angle_sample
// m_axis   | m_tvalid m_tready m_tdata[95:0]  | turn_count, position_count, speed_count
// cfg      | cfg_we cfg_addr cfg_wdata[14:0]  | 0: slow_speed_threshold, 1: glitch_limit
//
// One sample per cycle while the result side is not stalled; a sample passes through
// the input register, then the result register.
// Tracking state updates as each sample moves from the input register to the result register.
// A stalled result holds the input register, and s_tready drops once the input register is full.
// rst is synchronous: all tracking state clears, registers return to 1000 and 1500.
module encoder_multiturn_speed_tracker #(
  parameter int ANGLE_BITS = emst_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [emst_pkg::S_TDATA_W-1:0]    s_tdata,   // [13:0] angle_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [emst_pkg::M_TDATA_W-1:0]    m_tdata,   // [31:0] turn_count,
                                                       // [77:32] position_count,
                                                       // [92:78] speed_count
  input  logic                              cfg_we,
  input  logic [emst_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [emst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import emst_pkg::*;

  logic                    in_valid;
  logic [ANGLE_IN_W-1:0]   in_angle;
  logic                    advance;
  logic [THR_W-1:0]        threshold;
  logic [GLITCH_W-1:0]     glitch_limit;
  result_t                 res_next;
  result_t                 res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_angle <= s_tdata[ANGLE_IN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(M_TDATA_W-$bits(result_t)){1'b0}}, res};

  emst_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .threshold    (threshold),
    .glitch_limit (glitch_limit)
  );

  emst_track #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .angle_in     (in_angle),
    .threshold    (threshold),
    .glitch_limit (glitch_limit),
    .res          (res_next)
  );

endmodule
